// ----- design/text_console_writer_core_defines.svh -----
// Assertion macros used by the console writer datapath (tcw_dp).
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property, checked at every rising clock edge outside reset
`define TCW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("tcw: assertion failed");
// Same-cycle implication
`define TCW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tcw: implication failed");
`else
`define TCW_ASSERT(lbl, clk, rstn, prop)
`define TCW_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- design/tcw_pkg.sv -----
`timescale 1ns / 1ps

package tcw_pkg;

  // Default screen geometry
  localparam int unsigned DEF_SCREEN_COLUMNS = 80;
  localparam int unsigned DEF_SCREEN_LINES   = 25;

  // Character codes that only move the cursor
  localparam logic [7:0]  CHAR_TAB = 8'd9;
  localparam logic [7:0]  CHAR_LF  = 8'd10;
  localparam logic [7:0]  CHAR_CR  = 8'd13;
  localparam int unsigned TAB_STEP = 8;

  // Operation codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } tcw_mode_e;

  // Input beat
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } tcw_in_t;

  // Output beat
  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [4:0] cursor_line;
    logic [6:0] cursor_column;
    logic       did_scroll;
  } tcw_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic init_start;  // arm the power-up blanking sweep
    logic load;        // capture the input beat
    logic commit;      // update cursor, window base, start sweeps
    logic sweep_step;  // blank one cell and advance the sweep
    logic wr_cell;     // store the character cell
    logic rd_issue;    // read one cell into the read register
    logic out_load;    // fill the output register
  } tcw_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    tcw_mode_e mode;
    logic      do_scroll;
    logic      do_write;
    logic      rd_ok;
    logic      sweep_last;
    logic      out_free;
  } tcw_stat_t;

endpackage

// ----- design/tcw_ctrl.sv -----
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcw_pkg::tcw_stat_t st_i,
  output tcw_pkg::tcw_cmd_t  cmd_o
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_INIT_START,
    S_INIT_SWEEP,
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_WRITE,
    S_READ,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   wr_pend_q, wr_pend_d;

  // Next state and command decode
  always_comb begin
    state_d   = state_q;
    wr_pend_d = wr_pend_q;
    cmd_o     = '0;
    unique case (state_q)
      S_INIT_START: begin
        cmd_o.init_start = 1'b1;
        state_d          = S_INIT_SWEEP;
      end
      S_INIT_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (st_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.commit = 1'b1;
        wr_pend_d    = 1'b0;
        unique case (st_i.mode)
          MODE_PUT: begin
            wr_pend_d = st_i.do_write;
            if (st_i.do_scroll) state_d = S_SWEEP;
            else if (st_i.do_write) state_d = S_WRITE;
            else state_d = S_RESP;
          end
          MODE_READ:  state_d = st_i.rd_ok ? S_READ : S_RESP;
          MODE_CLEAR: state_d = S_SWEEP;
          default:    state_d = S_RESP;
        endcase
      end
      S_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (st_i.sweep_last) state_d = wr_pend_q ? S_WRITE : S_RESP;
      end
      S_WRITE: begin
        cmd_o.wr_cell = 1'b1;
        state_d       = S_RESP;
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_RESP;
      end
      S_RESP: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // State and registered flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT_START;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_pend_q <= wr_pend_d;
    end
  end

endmodule

// ----- design/tcw_dp.sv -----
`timescale 1ns / 1ps
`include "text_console_writer_core_defines.svh"

module tcw_dp #(
  parameter int unsigned SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
  parameter int unsigned SCREEN_LINES   = tcw_pkg::DEF_SCREEN_LINES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcw_pkg::tcw_cmd_t  cmd_i,
  output tcw_pkg::tcw_stat_t st_o,
  input  tcw_pkg::tcw_in_t   in_data_i,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tcw_pkg::tcw_out_t  out_data_o
);
  import tcw_pkg::*;

  localparam int unsigned CellCount = SCREEN_COLUMNS * SCREEN_LINES;
  localparam int unsigned ROW_W     = $clog2(SCREEN_LINES + 1);
  localparam int unsigned COL_W     = $clog2(SCREEN_COLUMNS + 1);
  localparam int unsigned BASE_W    = $clog2(SCREEN_LINES);
  localparam int unsigned ADDR_W    = $clog2(CellCount);

  localparam logic [ROW_W-1:0]  LinesR   = ROW_W'(SCREEN_LINES);
  localparam logic [ROW_W-1:0]  LastRow  = ROW_W'(SCREEN_LINES - 1);
  localparam logic [COL_W-1:0]  ColsC    = COL_W'(SCREEN_COLUMNS);
  localparam logic [COL_W:0]    TabStep  = (COL_W + 1)'(TAB_STEP);
  localparam logic [BASE_W-1:0] LastBase = BASE_W'(SCREEN_LINES - 1);
  localparam logic [ADDR_W-1:0] LastCell = ADDR_W'(CellCount - 1);
  localparam logic [ADDR_W-1:0] ColsA    = ADDR_W'(SCREEN_COLUMNS);
  localparam logic [ROW_W:0]    LinesW   = (ROW_W + 1)'(SCREEN_LINES);

  localparam logic [7:0] ResetAttr   = 8'd15;

  // Cursor, window base and configuration
  logic [7:0]        attr_q, attr_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [BASE_W-1:0] base_q, base_d;
  logic [ADDR_W-1:0] sweep_addr_q, sweep_addr_d;
  logic [ADDR_W-1:0] sweep_end_q, sweep_end_d;
  logic              out_valid_q, out_valid_d;

  // Item payload
  tcw_in_t           item_q;
  logic [ROW_W-1:0]  pos_row_q, pos_row_d;
  logic [COL_W-1:0]  pos_col_q, pos_col_d;
  logic [7:0]        sweep_attr_q, sweep_attr_d;
  logic              scrolled_q, scrolled_d;
  logic              rd_hit_q, rd_hit_d;
  logic [15:0]       rd_data_q;
  tcw_out_t          out_q;

  // Screen memory, rows stored circularly from base_q
  logic [15:0]       mem [CellCount];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;

  // Put-character cursor logic
  logic              pre_scroll, wrap, wrap_scroll;
  logic [ROW_W-1:0]  r1, r_inc, wr_row, put_row;
  logic [COL_W-1:0]  c1, wr_col, tab_col, put_col;
  logic [COL_W:0]    tab_sum, tab_next;
  logic              put_scroll, put_write;

  always_comb begin
    pre_scroll  = (row_q >= LinesR);
    r1          = pre_scroll ? LastRow : row_q;
    c1          = pre_scroll ? '0 : col_q;
    r_inc       = r1 + ROW_W'(1);
    tab_sum     = {1'b0, c1} + TabStep;
    tab_next    = {tab_sum[COL_W:3], 3'b000};
    tab_col     = (tab_next > {1'b0, ColsC}) ? ColsC : tab_next[COL_W-1:0];
    wrap        = (c1 >= ColsC);
    wrap_scroll = wrap && (r_inc >= LinesR);
    wr_row      = wrap ? (wrap_scroll ? LastRow : r_inc) : r1;
    wr_col      = wrap ? '0 : c1;
    put_scroll  = pre_scroll;
    put_write   = 1'b0;
    unique case (item_q.char_code)
      CHAR_LF: begin
        put_row = r_inc;
        put_col = '0;
      end
      CHAR_CR: begin
        put_row = r1;
        put_col = '0;
      end
      CHAR_TAB: begin
        put_row = r1;
        put_col = tab_col;
      end
      default: begin
        put_row    = wr_row;
        put_col    = wr_col + COL_W'(1);
        put_scroll = pre_scroll || wrap_scroll;
        put_write  = 1'b1;
      end
    endcase
  end

  // Logical to physical cell address
  logic [ROW_W:0]    phys_sum, phys_row;
  logic [ADDR_W-1:0] cell_addr, scroll_start;
  logic [BASE_W-1:0] base_next;
  logic              rd_ok;

  always_comb begin
    phys_sum     = (ROW_W + 1)'(pos_row_q) + (ROW_W + 1)'(base_q);
    phys_row     = (phys_sum >= LinesW) ? (phys_sum - LinesW) : phys_sum;
    cell_addr    = ADDR_W'(phys_row) * ColsA + ADDR_W'(pos_col_q);
    scroll_start = ADDR_W'(base_q) * ColsA;
    base_next    = (base_q == LastBase) ? '0 : base_q + BASE_W'(1);
    rd_ok        = (32'(item_q.read_row) < SCREEN_LINES) &&
                   (32'(item_q.read_col) < SCREEN_COLUMNS);
  end

  // Status to controller
  always_comb begin
    st_o.mode       = tcw_mode_e'(item_q.mode);
    st_o.do_scroll  = put_scroll;
    st_o.do_write   = put_write;
    st_o.rd_ok      = rd_ok;
    st_o.sweep_last = (sweep_addr_q == sweep_end_q);
    st_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Next values of the cursor, window and sweep
  always_comb begin
    attr_d       = cfg_we_i ? cfg_wdata_i : attr_q;
    row_d        = row_q;
    col_d        = col_q;
    base_d       = base_q;
    sweep_addr_d = sweep_addr_q;
    sweep_end_d  = sweep_end_q;
    sweep_attr_d = sweep_attr_q;
    pos_row_d    = pos_row_q;
    pos_col_d    = pos_col_q;
    scrolled_d   = scrolled_q;
    rd_hit_d     = rd_hit_q;

    if (cmd_i.init_start) begin
      sweep_addr_d = '0;
      sweep_end_d  = LastCell;
      sweep_attr_d = ResetAttr;
    end
    if (cmd_i.sweep_step) sweep_addr_d = sweep_addr_q + ADDR_W'(1);

    if (cmd_i.commit) begin
      scrolled_d = 1'b0;
      rd_hit_d   = 1'b0;
      unique case (tcw_mode_e'(item_q.mode))
        MODE_PUT: begin
          row_d      = put_row;
          col_d      = put_col;
          pos_row_d  = wr_row;
          pos_col_d  = wr_col;
          scrolled_d = put_scroll;
          if (put_scroll) begin
            base_d       = base_next;
            sweep_addr_d = scroll_start;
            sweep_end_d  = scroll_start + ColsA - ADDR_W'(1);
            sweep_attr_d = attr_q;
          end
        end
        MODE_READ: begin
          pos_row_d = ROW_W'(item_q.read_row);
          pos_col_d = COL_W'(item_q.read_col);
          rd_hit_d  = rd_ok;
        end
        MODE_CLEAR: begin
          row_d        = '0;
          col_d        = '0;
          base_d       = '0;
          sweep_addr_d = '0;
          sweep_end_d  = LastCell;
          sweep_attr_d = attr_q;
        end
        default: ;
      endcase
    end

    if (cmd_i.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q       <= ResetAttr;
      row_q        <= '0;
      col_q        <= '0;
      base_q       <= '0;
      sweep_addr_q <= '0;
      sweep_end_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      attr_q       <= attr_d;
      row_q        <= row_d;
      col_q        <= col_d;
      base_q       <= base_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_end_q  <= sweep_end_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    pos_row_q    <= pos_row_d;
    pos_col_q    <= pos_col_d;
    sweep_attr_q <= sweep_attr_d;
    scrolled_q   <= scrolled_d;
    rd_hit_q     <= rd_hit_d;
    if (cmd_i.out_load) begin
      out_q.cell_char     <= rd_hit_q ? rd_data_q[7:0] : 8'h00;
      out_q.cell_attr     <= rd_hit_q ? rd_data_q[15:8] : 8'h00;
      out_q.cursor_line   <= 5'(row_q);
      out_q.cursor_column <= 7'(col_q);
      out_q.did_scroll    <= scrolled_q;
    end
  end

  // Memory write port: blanking sweep or character store
  always_comb begin
    mem_we    = cmd_i.sweep_step || cmd_i.wr_cell;
    mem_waddr = cmd_i.sweep_step ? sweep_addr_q : cell_addr;
    mem_wdata = cmd_i.sweep_step ? {sweep_attr_q, 8'h00} : {attr_q, item_q.char_code};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.rd_issue) rd_data_q <= mem[cell_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `TCW_ASSERT(a_cursor_range, clk_i, rst_ni,
              (32'(row_q) <= SCREEN_LINES) && (32'(col_q) <= SCREEN_COLUMNS))
  `TCW_ASSERT(a_base_range, clk_i, rst_ni, 32'(base_q) < SCREEN_LINES)
  `TCW_ASSERT_IMP(a_sweep_bound, clk_i, rst_ni, cmd_i.sweep_step,
                  sweep_addr_q <= sweep_end_q)
  `TCW_ASSERT_IMP(a_store_in_screen, clk_i, rst_ni, cmd_i.wr_cell || cmd_i.rd_issue,
                  (32'(pos_row_q) < SCREEN_LINES) && (32'(pos_col_q) < SCREEN_COLUMNS))

endmodule

// ----- design/text_console_writer_core.sv -----
`timescale 1ns / 1ps
// Sequence: an input beat is loaded in S_IDLE and committed in S_EXEC; then a put that
//   scrolls blanks the new bottom row in S_SWEEP, a clear blanks every cell in S_SWEEP,
//   a printable put stores its cell in S_WRITE, an in-range read fetches its cell in
//   S_READ, and S_RESP fills the output register; one cell-memory write per cycle.
// Throughput: one item at a time; the next beat is taken once the result is registered.
// Reset: cursor homes, attribute becomes 15, then a setup state and a blanking pass over
//   all SCREEN_LINES*SCREEN_COLUMNS cells while no input beat is accepted.

module text_console_writer_core #(
  parameter int unsigned SCREEN_COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
  parameter int unsigned SCREEN_LINES   = tcw_pkg::DEF_SCREEN_LINES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tcw_pkg::tcw_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tcw_pkg::tcw_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i
);
  import tcw_pkg::*;

  tcw_cmd_t  cmd;
  tcw_stat_t st;

  // Sequencer
  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Cursor, screen memory and output register
  tcw_dp #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_LINES   (SCREEN_LINES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/text_console_checker.sv -----
`timescale 1ns / 1ps

module text_console_checker #(
  parameter int unsigned COLUMNS = tcw_pkg::DEF_SCREEN_COLUMNS,
  parameter int unsigned LINES   = tcw_pkg::DEF_SCREEN_LINES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  tcw_pkg::tcw_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  tcw_pkg::tcw_out_t out_data_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  output int                mismatch_count_o,
  output int                reports_pending_o
);
  import tcw_pkg::*;

  localparam int unsigned CELLS      = COLUMNS * LINES;
  localparam logic [7:0]  RESET_ATTR = 8'd15;

  // Shadow copy of the screen, cursor and attribute
  logic [15:0] screen_q [CELLS];
  int unsigned row_q;
  int unsigned col_q;
  logic [7:0]  attr_q;

  // Cursor and cell reports still owed by the block, oldest first
  tcw_out_t cursor_reports_q [$];

  // Move every line up one, blank the bottom line
  task automatic scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen_q[i] = screen_q[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_q[i] = {attr_q, 8'h00};
    if (row_q > 0) row_q--;
    col_q = 0;
  endtask

  // Apply one input beat to the shadow screen and build its report
  task automatic console_step(input tcw_in_t item, output tcw_out_t report);
    logic        scrolled;
    int unsigned next_col;
    scrolled = 1'b0;
    report   = '0;
    case (item.mode)
      MODE_PUT: begin
        if (row_q >= LINES) begin
          scroll_screen();
          scrolled = 1'b1;
        end
        if (item.char_code == CHAR_LF) begin
          row_q++;
          col_q = 0;
        end else if (item.char_code == CHAR_CR) begin
          col_q = 0;
        end else if (item.char_code == CHAR_TAB) begin
          next_col = (col_q + TAB_STEP) & ~(TAB_STEP - 1);
          col_q = (next_col > COLUMNS) ? COLUMNS : next_col;
        end else begin
          // wrap at line end, which may scroll
          if (col_q >= COLUMNS) begin
            col_q = 0;
            row_q++;
            if (row_q >= LINES) begin
              scroll_screen();
              scrolled = 1'b1;
            end
          end
          if (row_q < LINES && col_q < COLUMNS)
            screen_q[row_q * COLUMNS + col_q] = {attr_q, item.char_code};
          col_q++;
          if (col_q > COLUMNS) col_q = COLUMNS;
        end
      end
      MODE_READ: begin
        if (item.read_row < LINES && item.read_col < COLUMNS)
          {report.cell_attr, report.cell_char} = screen_q[item.read_row * COLUMNS + item.read_col];
      end
      MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_q[i] = {attr_q, 8'h00};
        row_q = 0;
        col_q = 0;
      end
      default: ;
    endcase
    report.cursor_line   = row_q[4:0];
    report.cursor_column = col_q[6:0];
    report.did_scroll    = scrolled;
  endtask

  task automatic check_field(input string label, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      mismatch_count_o++;
    end
  endtask

  // Track handshakes: compare result beats, predict input beats, follow cfg writes
  always @(posedge clk_i or negedge rst_ni) begin
    tcw_out_t report;
    tcw_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) screen_q[i] = {RESET_ATTR, 8'h00};
      row_q  = 0;
      col_q  = 0;
      attr_q = RESET_ATTR;
      cursor_reports_q.delete();
      mismatch_count_o  = 0;
      reports_pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (cursor_reports_q.size() == 0) begin
          $display("%0t: result beat with none pending, expected nothing, actual %h",
                   $time, out_data_i);
          mismatch_count_o++;
        end else begin
          want = cursor_reports_q.pop_front();
          check_field("cell_char", want.cell_char, out_data_i.cell_char);
          check_field("cell_attr", want.cell_attr, out_data_i.cell_attr);
          check_field("cursor_line", want.cursor_line, out_data_i.cursor_line);
          check_field("cursor_column", want.cursor_column, out_data_i.cursor_column);
          check_field("did_scroll", want.did_scroll, out_data_i.did_scroll);
        end
      end
      if (in_valid_i && in_ready_i) begin
        console_step(in_data_i, report);
        cursor_reports_q.push_back(report);
      end
      if (cfg_we_i) attr_q = cfg_wdata_i;
      reports_pending_o = cursor_reports_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  localparam int unsigned COLUMNS     = DEF_SCREEN_COLUMNS;
  localparam int unsigned LINES       = DEF_SCREEN_LINES;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned PHASE_BEATS = 200;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  tcw_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  tcw_out_t   out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  int mismatch_count;
  int reports_pending;
  int unsigned beats_sent = 0;
  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 64;

  always #5 clk = ~clk;

  text_console_writer_core #(
    .SCREEN_COLUMNS(COLUMNS),
    .SCREEN_LINES  (LINES)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  text_console_checker #(
    .COLUMNS(COLUMNS),
    .LINES  (LINES)
  ) u_console_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatch_count),
    .reports_pending_o(reports_pending)
  );

  // Receiver stalls at random
  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic tcw_in_t make_beat(tcw_mode_e mode, logic [7:0] code,
                                        logic [4:0] row, logic [6:0] col);
    tcw_in_t beat;
    beat.mode      = mode;
    beat.char_code = code;
    beat.read_row  = row;
    beat.read_col  = col;
    return beat;
  endfunction

  function automatic tcw_in_t noise_beat();
    tcw_in_t beat;
    beat.mode      = 2'($urandom_range(3));
    beat.char_code = 8'($urandom_range(255));
    beat.read_row  = 5'($urandom_range(31));
    beat.read_col  = 7'($urandom_range(127));
    return beat;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input tcw_in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    beats_sent++;
  endtask

  // Stop sending and wait until every report has come back or DRAIN_LIMIT runs out
  task automatic drain_and_settle();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (reports_pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    drain_and_settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One burst of text-like traffic
  task automatic send_burst();
    tcw_in_t     beat;
    int unsigned pick;
    int unsigned run_len;
    pick = $urandom_range(99);
    if (pick < 50) begin
      run_len = $urandom_range(1, 12);
      repeat (run_len) begin
        beat = noise_beat();
        beat.mode = MODE_PUT;
        send_beat(beat);
      end
    end else if (pick < 60) begin
      // newline runs push the cursor past the last line
      run_len = $urandom_range(1, 30);
      repeat (run_len) begin
        beat = noise_beat();
        beat.mode = MODE_PUT;
        beat.char_code = CHAR_LF;
        send_beat(beat);
      end
    end else if (pick < 65) begin
      // a line longer than the screen forces a wrap
      run_len = $urandom_range(COLUMNS + 1, COLUMNS + 10);
      repeat (run_len) begin
        beat = noise_beat();
        beat.mode = MODE_PUT;
        beat.char_code = 8'($urandom_range(14, 255));
        send_beat(beat);
      end
    end else if (pick < 70) begin
      run_len = $urandom_range(1, 12);
      repeat (run_len) begin
        beat = noise_beat();
        beat.mode = MODE_PUT;
        beat.char_code = CHAR_TAB;
        send_beat(beat);
      end
    end else if (pick < 74) begin
      beat = noise_beat();
      beat.mode = MODE_PUT;
      beat.char_code = CHAR_CR;
      send_beat(beat);
    end else if (pick < 86) begin
      run_len = $urandom_range(1, 4);
      repeat (run_len) begin
        beat = noise_beat();
        beat.mode = MODE_READ;
        if ($urandom_range(99) < 80) begin
          beat.read_row = 5'($urandom_range(LINES - 1));
          beat.read_col = 7'($urandom_range(COLUMNS - 1));
        end
        send_beat(beat);
      end
    end else if (pick < 89) begin
      beat = noise_beat();
      beat.mode = MODE_CLEAR;
      send_beat(beat);
    end else begin
      run_len = $urandom_range(1, 3);
      repeat (run_len) send_beat(noise_beat());
    end
  endtask

  task automatic run_text_phase(input int unsigned count);
    int unsigned stop_at;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) send_burst();
  endtask

  initial begin
    #(64'd100_000_000);
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents, read bounds, each character class, nop, clear
    send_beat(make_beat(MODE_READ, 8'h00, 5'd0, 7'd0));
    send_beat(make_beat(MODE_READ, 8'hFF, 5'(LINES - 1), 7'(COLUMNS - 1)));
    send_beat(make_beat(MODE_READ, 8'h00, 5'(LINES), 7'd0));
    send_beat(make_beat(MODE_READ, 8'h00, 5'd0, 7'(COLUMNS)));
    send_beat(make_beat(MODE_READ, 8'h00, 5'h1F, 7'h7F));
    send_beat(make_beat(MODE_PUT, 8'h41, 5'h1F, 7'h7F));
    send_beat(make_beat(MODE_PUT, 8'h00, 5'd0, 7'd0));
    send_beat(make_beat(MODE_PUT, 8'hFF, 5'd0, 7'd0));
    send_beat(make_beat(MODE_PUT, CHAR_TAB, 5'd0, 7'd0));
    send_beat(make_beat(MODE_PUT, CHAR_TAB, 5'd0, 7'd0));
    send_beat(make_beat(MODE_PUT, 8'h7E, 5'd0, 7'd0));
    send_beat(make_beat(MODE_PUT, CHAR_CR, 5'd0, 7'd0));
    send_beat(make_beat(MODE_PUT, CHAR_LF, 5'd0, 7'd0));
    send_beat(make_beat(MODE_READ, 8'h00, 5'd0, 7'd0));
    send_beat(make_beat(MODE_READ, 8'h00, 5'd0, 7'd2));
    send_beat(make_beat(MODE_READ, 8'h00, 5'd0, 7'd16));
    send_beat(make_beat(MODE_NOP, 8'hFF, 5'h1F, 7'h7F));
    write_attribute(8'hFF);
    send_beat(make_beat(MODE_PUT, 8'h55, 5'd0, 7'd0));
    send_beat(make_beat(MODE_READ, 8'h00, 5'd1, 7'd0));
    send_beat(make_beat(MODE_CLEAR, 8'h00, 5'd0, 7'd0));
    send_beat(make_beat(MODE_READ, 8'h00, 5'(LINES - 1), 7'(COLUMNS - 1)));
    write_attribute(8'h00);
    send_beat(make_beat(MODE_CLEAR, 8'hFF, 5'h1F, 7'h7F));
    send_beat(make_beat(MODE_READ, 8'h00, 5'd10, 7'd40));

    // Random text, sender idles less than receiver
    run_text_phase(PHASE_BEATS);
    write_attribute(8'h1E);
    run_text_phase(PHASE_BEATS);
    write_attribute(8'hFF);

    // Receiver idles less than sender
    send_idle_pct = 64;
    recv_idle_pct = 35;
    run_text_phase(PHASE_BEATS);
    write_attribute(8'($urandom_range(255)));
    run_text_phase(PHASE_BEATS);
    write_attribute(8'h00);

    // Back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_text_phase(PHASE_BEATS);
    write_attribute(8'($urandom_range(255)));
    run_text_phase(PHASE_BEATS);

    drain_and_settle();
    if (reports_pending != 0)
      $display("%0t: %0d result beats never arrived", $time, reports_pending);
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
